[hw/rtl/slrs_pkg.sv]
// shared types and constants of the shuffled lcg random source
`timescale 1ns / 1ps
`default_nettype none

package slrs_pkg;

    // generator word and modulus
    localparam int unsigned VALUE_W = 31;
    localparam logic [VALUE_W-1:0] MODULUS = 31'h7FFF_FFFF;
    localparam int unsigned MULT = 16807;
    localparam int unsigned MULT_W = 15;

    // generator steps thrown away before the table fill
    localparam int unsigned WARMUP = 8;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_DIV,
        ST_READ,
        ST_WRITE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/shuffled_lcg_random_source.sv]
// top level: park-miller generator with a shuffle table, sequencer and output register
//
//  channel  | direction | ports                         | content
//  ---------+-----------+-------------------------------+------------------------------
//  s        | in        | i_s_tvalid/o_s_tready         | tuser: func, tdata: seed
//  m        | out       | o_m_tvalid/i_m_tready         | tdata: value
//
// after the item is taken, a draw runs the modular multiply and its fold, the index
// lookup, one table read and one table write; the next item is taken only once the
// block is back in idle, so no new item is taken before the last draw is through.
// a seeding item, or the first item after reset, adds the set-up: 8 warm-up steps
// and one step per table entry, all through the same multiply unit.
// reset is synchronous and needs no clearing pass; the table is filled before use.
// a result waits in the output register; the next item is taken meanwhile, and the
// block holds before its own table write until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module shuffled_lcg_random_source #(
    parameter int unsigned TABLE_SIZE = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    input  wire logic [31:0]    i_s_tdata,   // [30:0] seed, [31] zero
    input  wire logic           i_s_tuser,   // [0] func
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic      [31:0]    o_m_tdata    // [30:0] value, [31] zero
);

    localparam int unsigned VW        = slrs_pkg::VALUE_W;
    localparam int unsigned AW        = $clog2(TABLE_SIZE);
    localparam int unsigned STEPS     = slrs_pkg::WARMUP + TABLE_SIZE;
    localparam int unsigned CNTW      = $clog2(STEPS);

    slrs_pkg::t_state   r_state;
    slrs_pkg::t_state   n_state;

    logic [VW-1:0]      r_gen;
    logic [VW-1:0]      n_gen;
    logic [VW-1:0]      r_last;
    logic [VW-1:0]      n_last;
    logic [CNTW-1:0]    r_cnt;
    logic [CNTW-1:0]    n_cnt;
    logic               r_setup;
    logic               n_setup;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [VW-1:0]      r_out_value;
    logic [VW-1:0]      n_out_value;

    logic               in_take;
    logic               out_free;
    logic [CNTW-1:0]    fill_idx;
    logic               mul_en;
    logic [VW-1:0]      mul_y;
    logic               div_start;
    logic               div_done;
    logic [AW-1:0]      div_quot;
    logic               tbl_we;
    logic [AW-1:0]      tbl_waddr;
    logic [VW-1:0]      tbl_wdata;
    logic               tbl_re;
    logic [AW-1:0]      tbl_raddr;
    logic [VW-1:0]      tbl_rdata;

    assign o_s_tready = (r_state == slrs_pkg::ST_IDLE);
    assign in_take    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign fill_idx   = r_cnt - CNTW'(slrs_pkg::WARMUP);

    // shared modular multiply unit
    slrs_mod_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_x   (r_gen),
        .o_y   (mul_y)
    );

    // index divider
    slrs_idx_div #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_last),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // shuffle table
    slrs_table #(
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slrs_pkg::ST_IDLE: begin
                if (in_take) begin
                    n_state = slrs_pkg::ST_MUL;
                end
            end
            slrs_pkg::ST_MUL: begin
                n_state = slrs_pkg::ST_RED;
            end
            slrs_pkg::ST_RED: begin
                if (r_setup) begin
                    n_state = slrs_pkg::ST_MUL;
                end else begin
                    n_state = slrs_pkg::ST_DIV;
                end
            end
            slrs_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = slrs_pkg::ST_READ;
                end
            end
            slrs_pkg::ST_READ: begin
                n_state = slrs_pkg::ST_WRITE;
            end
            slrs_pkg::ST_WRITE: begin
                if (out_free) begin
                    n_state = slrs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slrs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control and next values
    always_comb begin
        n_gen       = r_gen;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_setup     = r_setup;
        n_out_value = r_out_value;
        n_out_valid = r_out_valid && !i_m_tready;
        mul_en      = 1'b0;
        div_start   = 1'b0;
        tbl_we      = 1'b0;
        tbl_waddr   = AW'(TABLE_SIZE - 1) - fill_idx[AW-1:0];
        tbl_wdata   = mul_y;
        tbl_re      = 1'b0;
        if (AW'(TABLE_SIZE - 1) < div_quot
                || (TABLE_SIZE == (1 << AW) ? 1'b0 : div_quot == AW'(TABLE_SIZE))) begin
            tbl_raddr = AW'(TABLE_SIZE - 1);
        end else begin
            tbl_raddr = div_quot;
        end
        case (r_state)
            slrs_pkg::ST_IDLE: begin
                // reseed, or set up from the current state before the first draw
                if (in_take) begin
                    n_cnt = '0;
                    if (i_s_tuser) begin
                        n_gen   = i_s_tdata[VW-1:0];
                        n_setup = 1'b1;
                    end else begin
                        n_setup = (r_last == '0);
                    end
                end
            end
            slrs_pkg::ST_MUL: begin
                mul_en = 1'b1;
            end
            slrs_pkg::ST_RED: begin
                n_gen = mul_y;
                if (r_setup) begin
                    // fill runs from the last entry down to entry zero
                    if (r_cnt >= CNTW'(slrs_pkg::WARMUP)) begin
                        tbl_we = 1'b1;
                    end
                    if (r_cnt == CNTW'(STEPS - 1)) begin
                        n_last  = mul_y;
                        n_setup = 1'b0;
                    end else begin
                        n_cnt = r_cnt + CNTW'(1);
                    end
                end else begin
                    div_start = 1'b1;
                end
            end
            slrs_pkg::ST_DIV: begin
            end
            slrs_pkg::ST_READ: begin
                tbl_re = 1'b1;
            end
            slrs_pkg::ST_WRITE: begin
                // swap: picked entry goes out, new generator value takes its place
                tbl_waddr = tbl_raddr;
                tbl_wdata = r_gen;
                if (out_free) begin
                    tbl_we      = 1'b1;
                    n_last      = tbl_rdata;
                    n_out_value = tbl_rdata;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slrs_pkg::ST_IDLE;
            r_gen       <= VW'(1);
            r_last      <= '0;
            r_setup     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_last      <= n_last;
            r_setup     <= n_setup;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_out_value <= n_out_value;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_value};

    // drawn values come from a filled table and lie strictly inside the modulus
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[VW-1:0] != '0 && o_m_tdata[VW-1:0] != slrs_pkg::MODULUS))
        else $error("drawn value out of range");

    // set-up never remains pending once the block is back at rest
    a_setup_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slrs_pkg::ST_IDLE) |-> !r_setup)
        else $error("set-up flag left set in idle");

    // the draw index is only formed from a set-up last output
    a_last_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slrs_pkg::ST_DIV) |-> (r_last != '0))
        else $error("index taken from an unfilled last output");

    // the generator has stepped to a legal value before the swap
    a_gen_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == slrs_pkg::ST_WRITE) |-> (r_gen != '0 && r_gen != slrs_pkg::MODULUS))
        else $error("generator state illegal at table swap");

endmodule

`default_nettype wire

[hw/rtl/slrs_mod_mul.sv]
// modular multiply unit: x * 16807 mod (2^31 - 1), product registered, fold after
`timescale 1ns / 1ps
`default_nettype none

module slrs_mod_mul (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [slrs_pkg::VALUE_W-1:0]    i_x,
    output logic      [slrs_pkg::VALUE_W-1:0]    o_y
);

    localparam int unsigned PW = slrs_pkg::VALUE_W + slrs_pkg::MULT_W;
    localparam int unsigned SW = slrs_pkg::VALUE_W + 1;

    logic [PW-1:0]                  r_prod;
    logic [slrs_pkg::VALUE_W-1:0]   legal_x;
    logic [SW-1:0]                  sum;

    // zero and the modulus itself would lock the generator, load one instead
    always_comb begin
        if (i_x == '0 || i_x == slrs_pkg::MODULUS) begin
            legal_x = slrs_pkg::VALUE_W'(1);
        end else begin
            legal_x = i_x;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(legal_x) * PW'(slrs_pkg::MULT);
        end
    end

    // mersenne fold: high part plus low part, one conditional subtract
    always_comb begin
        sum = SW'(r_prod[PW-1:slrs_pkg::VALUE_W]) + SW'(r_prod[slrs_pkg::VALUE_W-1:0]);
        if (sum >= SW'(slrs_pkg::MODULUS)) begin
            o_y = slrs_pkg::VALUE_W'(sum - SW'(slrs_pkg::MODULUS));
        end else begin
            o_y = slrs_pkg::VALUE_W'(sum);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/slrs_idx_div.sv]
// table index unit: last output divided by a constant, coarse lookup plus one correction
`timescale 1ns / 1ps
`default_nettype none

module slrs_idx_div #(
    parameter int unsigned TABLE_SIZE = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [slrs_pkg::VALUE_W-1:0]    i_dividend,
    output logic                                 o_done,
    output logic      [$clog2(TABLE_SIZE)-1:0]   o_quot
);

    localparam int unsigned QW = $clog2(TABLE_SIZE);
    localparam longint unsigned DIVISOR =
        1 + (longint'(slrs_pkg::MODULUS) - 1) / TABLE_SIZE;
    // bits below this shift never move the quotient by more than one
    localparam int unsigned SH = $clog2(DIVISOR + 1) - 1;
    localparam int unsigned TW = slrs_pkg::VALUE_W - SH;
    localparam int unsigned NT = 1 << TW;
    localparam int unsigned LW = slrs_pkg::VALUE_W + 1;

    logic [QW-1:0]  lut_q0  [NT];
    logic [LW-1:0]  lut_lim [NT];
    logic [TW-1:0]  top_bits;
    logic [QW-1:0]  q0;
    logic           bump;
    logic           r_busy;
    logic [QW-1:0]  r_quot;
    logic [QW-1:0]  n_quot;

    // constant tables: coarse quotient of each top-bit value and the next boundary
    for (genvar k = 0; k < NT; k++) begin : g_lut
        localparam longint unsigned Q0 = (longint'(k) << SH) / DIVISOR;
        assign lut_q0[k]  = QW'(Q0);
        assign lut_lim[k] = LW'((Q0 + 1) * DIVISOR);
    end

    // coarse quotient, raised by one when the dividend reaches the next boundary
    assign top_bits = i_dividend[slrs_pkg::VALUE_W-1:SH];
    assign q0       = lut_q0[top_bits];
    assign bump     = LW'(i_dividend) >= lut_lim[top_bits];
    assign n_quot   = q0 + QW'(bump);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= i_start;
        end
    end

    // quotient register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= n_quot;
        end
    end

    // done and quotient are valid in the cycle after start
    assign o_done = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

[hw/rtl/slrs_table.sv]
// shuffle table memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module slrs_table #(
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [$clog2(DEPTH)-1:0]        i_waddr,
    input  wire logic [slrs_pkg::VALUE_W-1:0]    i_wdata,
    input  wire logic                            i_re,
    input  wire logic [$clog2(DEPTH)-1:0]        i_raddr,
    output logic      [slrs_pkg::VALUE_W-1:0]    o_rdata
);

    logic [slrs_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [slrs_pkg::VALUE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// testbench of the shuffled lcg random source: directed and random items against a predictor
`timescale 1ns / 1ps

module tb_top;

    // block size and derived constants
    localparam int unsigned TABLE_SIZE = 32;
    localparam int unsigned VW = slrs_pkg::VALUE_W;
    localparam longint unsigned INDEX_DIV = 1 + (64'(slrs_pkg::MODULUS) - 1) / TABLE_SIZE;
    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_SEED = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 120;
    localparam int unsigned LONG_HOLD = 400;
    localparam int unsigned RANDOM_ITEMS = 400;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_s_tvalid = 1'b0;
    logic           o_s_tready;
    logic [31:0]    i_s_tdata = '0;  // [30:0] seed, [31] zero
    logic           i_s_tuser = 1'b0;  // [0] func
    logic           o_m_tvalid;
    logic           i_m_tready = 1'b0;
    logic [31:0]    o_m_tdata;  // [30:0] value, [31] zero

    // predictor state
    logic [VW-1:0] gen_state = 31'd1;
    logic [VW-1:0] shuffle_tab [TABLE_SIZE];
    logic [VW-1:0] last_value = '0;

    logic [VW-1:0] expected_values [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    shuffled_lcg_random_source #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // one generator step
    function automatic logic [VW-1:0] lcg_step(input logic [VW-1:0] x);
        logic [63:0] prod;
        prod = 64'(x) * 64'(slrs_pkg::MULT);
        return VW'(prod % 64'(slrs_pkg::MODULUS));
    endfunction

    // zero and the modulus would lock the generator
    function automatic logic [VW-1:0] legal_seed(input logic [VW-1:0] s);
        if (s == '0 || s == slrs_pkg::MODULUS) begin
            return 31'd1;
        end
        return s;
    endfunction

    // warm-up, then fill the table from the top entry down
    function automatic void fill_table(input logic [VW-1:0] s);
        logic [VW-1:0] x;
        x = legal_seed(s);
        for (int i = 0; i < slrs_pkg::WARMUP; i++) begin
            x = lcg_step(x);
        end
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            x = lcg_step(x);
            shuffle_tab[i] = x;
        end
        gen_state = x;
        last_value = shuffle_tab[0];
    endfunction

    // value the block returns for one item
    function automatic logic [VW-1:0] shuffled_draw(input logic func,
                                                    input logic [VW-1:0] seed);
        longint unsigned idx;
        if (func == FUNC_SEED) begin
            fill_table(seed);
        end else if (last_value == '0) begin
            fill_table(gen_state);
        end
        gen_state = lcg_step(legal_seed(gen_state));
        idx = 64'(last_value) / INDEX_DIV;
        if (idx >= TABLE_SIZE) begin
            idx = TABLE_SIZE - 1;
        end
        last_value = shuffle_tab[idx];
        shuffle_tab[idx] = gen_state;
        return last_value;
    endfunction

    // predict on every accepted input item
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            expected_values.push_back(shuffled_draw(i_s_tuser, i_s_tdata[VW-1:0]));
        end
    end

    // compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        logic [VW-1:0] exp_value;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_values.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_m_tdata);
                mismatch_count++;
            end else begin
                exp_value = expected_values.pop_front();
                if (o_m_tdata !== {1'b0, exp_value}) begin
                    $display("%0t: value mismatch, expected %h, got %h",
                             $time, {1'b0, exp_value}, o_m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold when requested
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // offer one item and wait until it is taken
    task automatic send_item(input logic func, input logic [VW-1:0] seed);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= func;
        i_s_tdata <= {1'b0, seed};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic source_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // draws right after reset: the first runs the set-up from the reset generator state
    task automatic test_draw_before_seed();
        repeat (3) begin
            send_item(FUNC_DRAW, VW'($urandom()));
        end
        source_idle();
    endtask

    // seed extremes, each followed by draws
    task automatic test_seed_extremes();
        logic [VW-1:0] seeds [6];
        seeds = '{31'd0, 31'd1, 31'h7FFF_FFFE, 31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA};
        foreach (seeds[i]) begin
            send_item(FUNC_SEED, seeds[i]);
            send_item(FUNC_DRAW, ~seeds[i]);
            send_item(FUNC_DRAW, seeds[i]);
        end
        source_idle();
    endtask

    // long receiver hold while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        hold_req++;
        repeat (20) begin
            send_item(FUNC_DRAW, VW'($urandom()));
        end
        send_item(FUNC_SEED, VW'($urandom()));
        send_item(FUNC_DRAW, VW'($urandom()));
        source_idle();
    endtask

    // mostly draws with occasional reseeds
    task automatic test_random_items(input int unsigned n, input int unsigned src_pct,
                                     input int unsigned sink_pct);
        int unsigned r;
        logic [VW-1:0] seed;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        repeat (n) begin
            r = $urandom_range(0, 99);
            seed = VW'($urandom());
            if (r < 6) begin
                if ($urandom_range(0, 9) == 0) begin
                    seed = ($urandom_range(0, 1) == 0) ? 31'd0 : slrs_pkg::MODULUS;
                end
                send_item(FUNC_SEED, seed);
            end else begin
                send_item(FUNC_DRAW, seed);
            end
        end
        source_idle();
    endtask

    initial begin
        src_idle_pct = 6;
        sink_idle_pct = 61;
        foreach (shuffle_tab[i]) begin
            shuffle_tab[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_draw_before_seed();
        test_seed_extremes();
        test_output_backpressure();
        test_random_items(RANDOM_ITEMS, 6, 61);
        test_random_items(RANDOM_ITEMS, 61, 6);
        test_random_items(RANDOM_ITEMS, 0, 0);

        // drain and let any stray result show up
        while (expected_values.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/slrs_pkg.sv
hw/rtl/slrs_mod_mul.sv
hw/rtl/slrs_idx_div.sv
hw/rtl/slrs_table.sv
hw/rtl/shuffled_lcg_random_source.sv
tb/tb_top.sv
